FILE: rtl/core/sorted_unique_rate_table_defines.svh
// assertion macros shared by the rate table rtl
`ifndef SORTED_UNIQUE_RATE_TABLE_DEFINES_SVH
`define SORTED_UNIQUE_RATE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, muted during reset
`define SURT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("surt same-cycle check failed");

// next-cycle implication
`define SURT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("surt next-cycle check failed");

`endif

FILE: rtl/core/surt_pkg.sv
// types and constants of the sorted rate table
`default_nettype none
package surt_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int RATE_W      = 24;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_COMPACT = 3'd2,
    ACT_READ    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EXISTS = 3'd2,
    ST_ABSENT = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e  op;
    rate_t key;
  } cell_cmd_t;

  // flags and data handed from one cell to the next one up
  typedef struct packed {
    rate_t entry;
    logic  ge;   // valid and entry >= key
    logic  hit;  // this or a lower cell matches key
  } cell_link_t;

endpackage
`default_nettype wire

FILE: rtl/core/surt_cell.sv
// one compare-and-shift slot of the rate table
`default_nettype none
module surt_cell
  import surt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_cmd_t  cmd_i,
  input  wire logic       valid_i,    // slot lies below the count
  input  wire logic       at_count_i, // slot is the first free one
  input  wire cell_link_t left_i,
  input  wire rate_t      right_entry_i,
  output cell_link_t      link_o,
  output logic            eq_o
);

  rate_t entry_q, entry_d;
  logic  ge;

  assign eq_o = valid_i && (entry_q == cmd_i.key);
  assign ge   = valid_i && (entry_q >= cmd_i.key);

  assign link_o.entry = entry_q;
  assign link_o.ge    = ge;
  assign link_o.hit   = left_i.hit | eq_o;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CMD_INSERT: begin
        // slots at or above the insertion point move up, the point itself takes the key
        if (ge || at_count_i) begin
          entry_d = left_i.ge ? left_i.entry : cmd_i.key;
        end
      end
      CMD_SHIFT: begin
        if (link_o.hit) begin
          entry_d = right_entry_i;
        end
      end
      CMD_CLEAR: entry_d = '0;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_unique_rate_table.sv
// top level of the sorted, duplicate-free rate table
//
// usage:
//   requests enter on the slave stream: tuser carries the action (insert,
//   remove, compact zeros, read entry, clear all), tdata the rate and the
//   read index. every request yields exactly one response on the master
//   stream with status, the entry read (zero unless a good read) and the
//   entry count after the action.
//   storage is a row of MAX_ENTRIES cells, each holding one rate and
//   exchanging its entry and compare flags with its neighbours, so an
//   insert, remove or compact settles across the whole row at once.
//   each response appears the cycle after its request; one request is taken
//   every cycle while the response register is empty or being drained.
//   the single output register is the only buffering: when the receiver
//   stalls, s_axis_tready drops until the held response is taken.
//   reset empties the table (all slots zero, count zero) and the output
//   register; there is no clearing pass.
`default_nettype none
`include "sorted_unique_rate_table_defines.svh"
module sorted_unique_rate_table
  import surt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // rate [23:0], index [26:24], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // action [2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // status [2:0], entry_rate [26:3],
                                          // entry_count [30:27], zero pad
);

  // request fields
  logic [2:0] req_action;
  rate_t      req_rate;
  logic [2:0] req_index;
  logic       req_acc;

  assign req_action = s_axis_tuser;
  assign req_rate   = s_axis_tdata[23:0];
  assign req_index  = s_axis_tdata[26:24];
  assign req_acc    = s_axis_tvalid && s_axis_tready;

  // count and the row of cells
  cnt_t       cnt_q, cnt_d;
  cell_cmd_t  cmd;
  cell_link_t link [MAX_ENTRIES+1];
  rate_t      right_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] eq_vec, valid_vec, at_cnt_vec, rd_sel;
  logic       found, full;

  assign link[0] = '{entry: '0, ge: 1'b0, hit: 1'b0};

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    assign valid_vec[k]  = cnt_t'(k) < cnt_q;
    assign at_cnt_vec[k] = cnt_t'(k) == cnt_q;
    assign rd_sel[k]     = valid_vec[k] && (int'(req_index) == k);
    if (k == MAX_ENTRIES - 1) begin : g_top
      assign right_entry[k] = '0;
    end else begin : g_mid
      assign right_entry[k] = link[k+2].entry;
    end

    surt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .valid_i       (valid_vec[k]),
      .at_count_i    (at_cnt_vec[k]),
      .left_i        (link[k]),
      .right_entry_i (right_entry[k]),
      .link_o        (link[k+1]),
      .eq_o          (eq_vec[k])
    );
  end

  assign found = |eq_vec;
  assign full  = cnt_q == cnt_t'(MAX_ENTRIES);

  // decode: the row only moves for a request that succeeds
  status_e status;
  rate_t   rd_entry;

  always_comb begin
    rd_entry = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (rd_sel[k]) begin
        rd_entry = link[k+1].entry;
      end
    end
  end

  always_comb begin
    cmd.key = (req_action == ACT_COMPACT) ? rate_t'(0) : req_rate;
    cmd.op  = CMD_HOLD;
    status  = ST_OK;
    cnt_d   = cnt_q;
    case (req_action)
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (found) begin
          status = ST_EXISTS;
        end else begin
          cmd.op = CMD_INSERT;
          cnt_d  = cnt_q + cnt_t'(1);
        end
      end
      ACT_REMOVE: begin
        if (found) begin
          cmd.op = CMD_SHIFT;
          cnt_d  = cnt_q - cnt_t'(1);
        end else begin
          status = ST_ABSENT;
        end
      end
      // sorted and unique, so a zero can only sit in slot 0
      ACT_COMPACT: begin
        if (found) begin
          cmd.op = CMD_SHIFT;
          cnt_d  = cnt_q - cnt_t'(1);
        end
      end
      ACT_READ: begin
        if (!(|rd_sel)) begin
          status = ST_RANGE;
        end
      end
      ACT_CLEAR: begin
        cmd.op = CMD_CLEAR;
        cnt_d  = '0;
      end
      default: status = ST_OK;
    endcase
    if (!req_acc) begin
      cmd.op = CMD_HOLD;
      cnt_d  = cnt_q;
    end
  end

  // response fields
  logic [CNT_W+3:0] cnt_ext;
  logic [3:0]       rsp_count;
  rate_t            rsp_entry;

  assign cnt_ext   = {4'b0000, cnt_d};
  assign rsp_count = cnt_ext[3:0];
  assign rsp_entry = (req_action == ACT_READ && status == ST_OK) ? rd_entry : '0;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      out_data_q <= {1'b0, rsp_count, rsp_entry, status};
    end
  end

  // row stays strictly ascending with zeros above the count
  logic order_ok;
  always_comb begin
    order_ok = 1'b1;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (!valid_vec[k] && link[k+1].entry != '0) begin
        order_ok = 1'b0;
      end
      if (k > 0 && valid_vec[k] && !(link[k].entry < link[k+1].entry)) begin
        order_ok = 1'b0;
      end
    end
  end

  `SURT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= cnt_t'(MAX_ENTRIES))
  `SURT_ASSERT_IMP(a_row_sorted, 1'b1, order_ok)
  `SURT_ASSERT_NXT(a_insert_grows, req_acc && cmd.op == CMD_INSERT,
                   cnt_q == $past(cnt_q) + cnt_t'(1))
  `SURT_ASSERT_NXT(a_shift_shrinks, req_acc && cmd.op == CMD_SHIFT,
                   cnt_q == $past(cnt_q) - cnt_t'(1))
  `SURT_ASSERT_IMP(a_stall_holds, !s_axis_tready, out_valid_q && !m_axis_tready)

endmodule
`default_nettype wire

FILE: verif/rate_table_checker.sv
// response checker with its own model of the sorted rate table
module rate_table_checker
  import surt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // rate [23:0], index [26:24], zero pad
  input  wire logic [2:0]  s_axis_tuser,  // action [2:0]
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,  // status [2:0], entry_rate [26:3],
                                          // entry_count [30:27], zero pad
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e status;
    rate_t   entry;
    cnt_t    count;
  } rate_response_t;

  rate_t          rate_slots [MAX_ENTRIES];
  int unsigned    slot_count;
  rate_response_t awaited_responses [$];
  rate_response_t oldest;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] rate table mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    errors_o++;
  endtask

  // applies one request to the shadow table and returns the response it yields
  function automatic rate_response_t table_apply(input logic [2:0] act, input rate_t r,
                                                 input logic [2:0] idx);
    rate_response_t resp;
    int unsigned    pos;
    int unsigned    kept;
    resp = '{status: ST_OK, entry: '0, count: '0};
    case (act)
      ACT_INSERT: begin
        if (slot_count >= MAX_ENTRIES) begin
          resp.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < slot_count && r > rate_slots[pos]) pos++;
          if (pos < slot_count && rate_slots[pos] == r) begin
            resp.status = ST_EXISTS;
          end else begin
            for (int unsigned k = slot_count; k > pos; k--) rate_slots[k] = rate_slots[k-1];
            rate_slots[pos] = r;
            slot_count++;
          end
        end
      end
      ACT_REMOVE: begin
        pos = 0;
        while (pos < slot_count && rate_slots[pos] != r) pos++;
        if (pos >= slot_count) begin
          resp.status = ST_ABSENT;
        end else begin
          slot_count--;
          for (int unsigned k = pos; k < slot_count; k++) rate_slots[k] = rate_slots[k+1];
          rate_slots[slot_count] = '0;
        end
      end
      ACT_COMPACT: begin
        kept = 0;
        for (int unsigned k = 0; k < slot_count; k++) begin
          if (rate_slots[k] != '0) begin
            rate_slots[kept] = rate_slots[k];
            kept++;
          end
        end
        for (int unsigned k = kept; k < slot_count; k++) rate_slots[k] = '0;
        slot_count = kept;
      end
      ACT_READ: begin
        if (idx < slot_count) resp.entry = rate_slots[idx];
        else resp.status = ST_RANGE;
      end
      ACT_CLEAR: begin
        foreach (rate_slots[k]) rate_slots[k] = '0;
        slot_count = 0;
      end
      default: ;  // spare codes leave the table alone
    endcase
    resp.count = cnt_t'(slot_count);
    return resp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (rate_slots[k]) rate_slots[k] = '0;
      slot_count = 0;
      awaited_responses.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // request first, so a same-edge response would still find its expectation
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_responses.push_back(table_apply(s_axis_tuser, s_axis_tdata[23:0],
                                                s_axis_tdata[26:24]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("response with no request pending", m_axis_tdata, 0);
        end else begin
          oldest = awaited_responses.pop_front();
          if (m_axis_tdata[2:0] != oldest.status)
            report_mismatch("status", m_axis_tdata[2:0], oldest.status);
          if (m_axis_tdata[26:3] != oldest.entry)
            report_mismatch("entry_rate", m_axis_tdata[26:3], oldest.entry);
          if (m_axis_tdata[30:27] != oldest.count)
            report_mismatch("entry_count", m_axis_tdata[30:27], oldest.count);
          if (m_axis_tdata[31] != 1'b0)
            report_mismatch("pad bit", m_axis_tdata[31], 0);
        end
      end
      pending_o = awaited_responses.size();
    end
  end

  final begin
    if (awaited_responses.size() != 0)
      $display("rate table: %0d responses never arrived", awaited_responses.size());
  end

endmodule

FILE: verif/tb_top.sv
// stimulus and verdict for the sorted rate table
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import surt_pkg::*;

  // spare action codes the block must ignore
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_ITEMS = 182;
  localparam int POOL_SIZE     = 16;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // rate [23:0], index [26:24], zero pad
  logic [2:0]  s_axis_tuser  = '0;  // action [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // status [2:0], entry_rate [26:3],
                                    // entry_count [30:27], zero pad

  int fail_count;
  int pending_count;
  int cycle_count   = 0;
  int src_idle_pct  = 0;  // chance of the sender pausing before a request
  int sink_stall_pct = 0; // chance of the receiver holding tready low

  always #4 clk_i = ~clk_i;

  sorted_unique_rate_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rate_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (fail_count),
    .pending_o     (pending_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** sorted_unique_rate_table: FAILED **");
      $finish;
    end
  end

  // receiver side: tready redrawn every cycle from the current stall chance
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // presents one request from a falling edge and returns on the falling edge
  // after it was taken; optional sender pauses come first
  task automatic send_request(input logic [2:0] act, input rate_t r, input logic [2:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, idx, r};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  rate_t rate_pool [POOL_SIZE];

  initial begin
    int    pick;
    int    mode;
    rate_t r;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling: empty table corner cases first
    send_request(ACT_READ,    24'd0,        3'd0);  // read of an empty table
    send_request(ACT_REMOVE,  24'd7,        3'd0);  // remove from empty
    send_request(ACT_COMPACT, 24'd0,        3'd0);  // compact with nothing used
    send_request(ACT_INSERT,  24'd0,        3'd0);  // zero is a legal rate, lands in slot 0
    send_request(ACT_INSERT,  24'hFFFFFF,   3'd0);  // largest rate
    send_request(ACT_INSERT,  24'd5,        3'd0);
    send_request(ACT_INSERT,  24'd5,        3'd0);  // duplicate refused
    send_request(ACT_INSERT,  24'd3,        3'd0);
    send_request(ACT_READ,    24'd0,        3'd7);  // index past the count
    send_request(ACT_COMPACT, 24'd0,        3'd0);  // drops the zero entry
    send_request(ACT_READ,    24'd0,        3'd0);
    // fill the table to its limit, zero included again
    send_request(ACT_INSERT,  24'd0,        3'd0);
    send_request(ACT_INSERT,  24'd1,        3'd0);
    send_request(ACT_INSERT,  24'd2,        3'd0);
    send_request(ACT_INSERT,  24'd4,        3'd0);
    send_request(ACT_INSERT,  24'h800000,   3'd0);
    send_request(ACT_INSERT,  24'd6,        3'd0);  // table full
    send_request(ACT_READ,    24'hFFFFFF,   3'd7);  // last slot holds the largest rate
    send_request(ACT_READ,    24'd0,        3'd0);
    send_request(ACT_REMOVE,  24'h800000,   3'd0);  // remove from the middle
    send_request(ACT_REMOVE,  24'd9,        3'd0);  // absent rate
    send_request(ACT_COMPACT, 24'd0,        3'd0);
    send_request(ACT_INSERT + 3'd5, 24'd11, 3'd1);  // spare code, ignored
    send_request(ACT_SPARE_FIRST + 3'd1, 24'hABCDEF, 3'd2);
    send_request(ACT_SPARE_LAST, 24'd0,     3'd3);
    send_request(ACT_CLEAR,   24'd0,        3'd0);
    send_request(ACT_READ,    24'd0,        3'd0);  // nothing left after clear

    // random part: each segment gets its own idling mode and its own pool of
    // rates, small enough that duplicates, full tables and hits on remove
    // come up all the time
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mode = seg % 4;
      src_idle_pct   = (mode == 1) ? 68 : (mode == 3) ? 24 : 0;
      sink_stall_pct = (mode == 2) ? 68 : (mode == 3) ? 24 : 0;
      foreach (rate_pool[k]) begin
        case ($urandom_range(3))
          0:       rate_pool[k] = rate_t'($urandom_range(15));
          1:       rate_pool[k] = 24'hFFFFFF - rate_t'($urandom_range(15));
          default: rate_pool[k] = rate_t'($urandom);
        endcase
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick = $urandom_range(99);
        // mostly pool rates so requests meet the table contents, some full-range noise
        r = ($urandom_range(99) < 82) ? rate_pool[$urandom_range(POOL_SIZE-1)]
                                      : rate_t'($urandom);
        if (pick < 40)      send_request(ACT_INSERT,  r, 3'($urandom));
        else if (pick < 65) send_request(ACT_REMOVE,  r, 3'($urandom));
        else if (pick < 88) send_request(ACT_READ,    r, 3'($urandom));
        else if (pick < 93) send_request(ACT_COMPACT, r, 3'($urandom));
        else if (pick < 96) send_request(ACT_CLEAR,   r, 3'($urandom));
        else send_request(3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)), r, 3'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain: the watchdog bounds this wait
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("** sorted_unique_rate_table: PASSED **");
    end else begin
      $display("** sorted_unique_rate_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/surt_pkg.sv
rtl/core/surt_cell.sv
rtl/core/sorted_unique_rate_table.sv
verif/rate_table_checker.sv
verif/tb_top.sv
